>>> design/slp_pkg.sv
// shared types and codes for the searchable lifo stack
// no dependencies; used by the controller, datapath, top level and checker
package slp_pkg;

  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic signed [WORD_W-1:0] UNDERFLOW_WORD = -32'sd1;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the request at the input
    logic scan_cmp;  // compare current entry during search
    logic scan_step; // advance the search pointer
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t in_op;
    logic    empty;
    logic    scan_hit;
    logic    scan_last;
    logic    out_free;
  } stat_t;

endpackage

>>> design/searchable_lifo_stack.sv
// top level of the searchable lifo stack
// depends on slp_pkg, slp_ctrl and slp_dp
//
// LIFO of signed 32-bit words with push, pop, peek and search, one request
// at a time. Push, pop and peek go from idle to the finish state, where the
// result is loaded once the output register is free, and the next request
// is taken back in idle; the stack memory has a single registered read
// port. Search walks the stack memory from the bottom through that port,
// one entry per cycle, and stops at the first match or at the top entry; on
// an empty stack it goes straight to the finish state. The output register
// lets a new request be taken while the last result still waits; a result
// that is not taken holds the next one back. Stack memory is not cleared
// after reset, and only live entries are ever read.
module searchable_lifo_stack #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // value
  input  logic [1:0]  s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // result_value[31:0], found[32], depth[40:33], zero pad
  output logic [1:0]  m_tuser   // status
);

  slp_pkg::cmd_t  cmd;
  slp_pkg::stat_t stat;

  slp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> design/slp_ctrl.sv
// controller state machine for the searchable lifo stack
// depends on slp_pkg for command and status structs
module slp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  slp_pkg::stat_t stat,
  output slp_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.accept    = (state == S_IDLE) && s_tvalid;
    cmd.scan_cmp  = (state == S_SCAN);
    cmd.scan_step = (state == S_SCAN) && !stat.scan_hit && !stat.scan_last;
    cmd.load_out  = (state == S_FINISH) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (stat.in_op == slp_pkg::OP_SEARCH && !stat.empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/slp_dp.sv
// datapath: stack memory, depth counter, search pointer and output register
// depends on slp_pkg for codes and command and status structs
module slp_dp #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          s_tuser,
  input  logic signed [slp_pkg::WORD_W-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [47:0]                         m_tdata,
  output logic [1:0]                          m_tuser,
  input  slp_pkg::cmd_t                       cmd,
  output slp_pkg::stat_t                      stat
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [slp_pkg::WORD_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]                     count;
  logic [AW-1:0]                     rd_ptr;
  logic [AW-1:0]                     rd_addr;
  logic signed [slp_pkg::WORD_W-1:0] rd_data;
  logic signed [slp_pkg::WORD_W-1:0] val_r;
  slp_pkg::opcode_t                  op_r;
  slp_pkg::opcode_t                  in_op;
  slp_pkg::status_t                  status_r;
  slp_pkg::status_t                  status_now;
  logic                              hit_r;
  logic                              full;
  logic                              empty;
  logic                              wr_en;
  logic                              rd_en;

  // result register
  logic signed [slp_pkg::WORD_W-1:0] out_value;
  logic                              out_found;
  slp_pkg::status_t                  out_status;
  logic [slp_pkg::DEPTH_W-1:0]       out_depth;
  logic signed [slp_pkg::WORD_W-1:0] res_value;

  assign in_op = slp_pkg::opcode_t'(s_tuser);
  assign full  = (count == CW'(STACK_DEPTH));
  assign empty = (count == '0);
  assign wr_en = cmd.accept && (in_op == slp_pkg::OP_PUSH) && !full;
  // no read on an empty stack, so only live entries are touched
  assign rd_en = (cmd.accept && !empty) || cmd.scan_step;

  always_comb begin
    if (cmd.scan_step) begin
      rd_addr = rd_ptr + AW'(1);
    end else if (in_op == slp_pkg::OP_SEARCH) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(count - CW'(1));
    end
  end

  always_comb begin
    status_now = slp_pkg::ST_OK;
    case (in_op)
      slp_pkg::OP_PUSH: if (full) status_now = slp_pkg::ST_OVERFLOW;
      slp_pkg::OP_POP,
      slp_pkg::OP_PEEK: if (empty) status_now = slp_pkg::ST_UNDERFLOW;
      default: status_now = slp_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      if (wr_en) begin
        count <= count + CW'(1);
      end else if (in_op == slp_pkg::OP_POP && !empty) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      val_r    <= s_tdata;
      status_r <= status_now;
      rd_ptr   <= '0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.scan_cmp && stat.scan_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.scan_step) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

  always_comb begin
    res_value = '0;
    if (status_r == slp_pkg::ST_UNDERFLOW) begin
      res_value = slp_pkg::UNDERFLOW_WORD;
    end else if (op_r == slp_pkg::OP_POP || op_r == slp_pkg::OP_PEEK) begin
      res_value = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value  <= res_value;
      out_found  <= hit_r && (op_r == slp_pkg::OP_SEARCH);
      out_status <= status_r;
      out_depth  <= slp_pkg::DEPTH_W'(count);
    end
  end

  assign m_tdata = {7'd0, out_depth, out_found, out_value};
  assign m_tuser = out_status;

  always_comb begin
    stat.in_op     = in_op;
    stat.empty     = empty;
    stat.scan_hit  = (rd_data == val_r);
    stat.scan_last = (CW'(rd_ptr) == count - CW'(1));
    stat.out_free  = !m_tvalid || m_tready;
  end

endmodule

>>> design/slp_checker.sv
// port-level checks for the searchable lifo stack, bound to the top level
// depends on slp_pkg for status codes
module slp_checker #(
  parameter int STACK_DEPTH = 128
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_underflow_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == slp_pkg::ST_UNDERFLOW |->
      m_tdata[31:0] == 32'hFFFF_FFFF && m_tdata[40:33] == 8'd0)
    else $error("underflow result not -1 on empty stack");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tuser == slp_pkg::ST_OK && m_tdata[31:0] == 32'd0)
    else $error("found set with non-search result");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == slp_pkg::ST_OVERFLOW |-> m_tdata[40:33] == 8'(STACK_DEPTH))
    else $error("overflow reported below full depth");

endmodule

bind searchable_lifo_stack slp_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_slp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
// self-checking testbench for searchable_lifo_stack
// depends on slp_pkg and the design sources; holds its own shadow stack to
// predict every response and checks each one as it leaves the block
`timescale 1ns / 1ps

module tb_top;

  localparam int STACK_DEPTH   = 128;
  localparam int RANDOM_REQS   = 1450;
  localparam int TAIL_CYCLES   = 200;
  localparam int TIMEOUT_NS    = 10_000_000;

  typedef struct {
    slp_pkg::opcode_t op;
    logic [31:0]      value;
    int unsigned      gap;
    bit               drain;  // hold this request until every response is back
  } stack_req_t;

  typedef struct packed {
    logic [slp_pkg::WORD_W-1:0]  result_value;
    logic                        found;
    slp_pkg::status_t            status;
    logic [slp_pkg::DEPTH_W-1:0] depth;
  } stack_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // value
  logic [1:0]  s_tuser = '0;   // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // result_value[31:0], found[32], depth[40:33], zero pad
  logic [1:0]  m_tuser;        // status

  stack_req_t  pending_reqs[$];
  stack_resp_t expected_resps[$];
  logic [31:0] shadow_words[STACK_DEPTH];
  int          shadow_count;
  stack_req_t  cur_req;
  bit          holding;
  int unsigned tx_wait;
  int unsigned rx_wait;
  bit          rx_burst;
  int          mismatches;

  searchable_lifo_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow stack: apply one accepted request and queue its response
  task automatic predict_stack_op(input slp_pkg::opcode_t op, input logic [31:0] word);
    stack_resp_t r;
    r.result_value = '0;
    r.found        = 1'b0;
    r.status       = slp_pkg::ST_OK;
    case (op)
      slp_pkg::OP_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          r.status = slp_pkg::ST_OVERFLOW;
        end else begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      slp_pkg::OP_POP: begin
        if (shadow_count == 0) begin
          r.status       = slp_pkg::ST_UNDERFLOW;
          r.result_value = slp_pkg::UNDERFLOW_WORD;
        end else begin
          shadow_count--;
          r.result_value = shadow_words[shadow_count];
        end
      end
      slp_pkg::OP_PEEK: begin
        if (shadow_count == 0) begin
          r.status       = slp_pkg::ST_UNDERFLOW;
          r.result_value = slp_pkg::UNDERFLOW_WORD;
        end else begin
          r.result_value = shadow_words[shadow_count - 1];
        end
      end
      slp_pkg::OP_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == word) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.depth = shadow_count[slp_pkg::DEPTH_W-1:0];
    expected_resps.push_back(r);
  endtask

  // driver: one request in hand, gap counted down before it is offered
  always @(posedge clk) begin : req_driver
    logic offer;
    if (rst) begin
      holding       = 1'b0;
      tx_wait       = 0;
      cur_req.op    = slp_pkg::OP_PUSH;
      cur_req.value = '0;
      cur_req.gap   = 0;
      cur_req.drain = 1'b0;
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_stack_op(cur_req.op, cur_req.value);
        holding = 1'b0;
        offer   = 1'b0;
      end
      if (!offer) begin
        if (!holding && pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          holding = 1'b1;
          tx_wait = cur_req.gap;
        end
        if (holding && !(cur_req.drain && expected_resps.size() != 0)) begin
          if (tx_wait == 0) offer = 1'b1;
          else tx_wait--;
        end
      end
      s_tvalid <= offer;
      s_tdata  <= cur_req.value;
      s_tuser  <= cur_req.op;
    end
  end

  // monitor: check each response against the oldest prediction
  always @(posedge clk) begin : resp_monitor
    stack_resp_t exp_r;
    stack_resp_t got;
    int unsigned next_wait;
    if (rst) begin
      rx_wait  = 0;
      rx_burst = 1'b0;
      m_tready <= 1'b0;
    end else begin
      next_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (m_tvalid && m_tready) begin
        got.result_value = m_tdata[31:0];
        got.found        = m_tdata[32];
        got.depth        = m_tdata[40:33];
        got.status       = slp_pkg::status_t'(m_tuser);
        if (expected_resps.size() == 0) begin
          $display("%0t: response with none pending: value %h found %b status %0d depth %0d",
                   $time, got.result_value, got.found, got.status, got.depth);
          mismatches++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (got.result_value !== exp_r.result_value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, exp_r.result_value, got.result_value);
            mismatches++;
          end
          if (got.found !== exp_r.found) begin
            $display("%0t: found expected %b actual %b", $time, exp_r.found, got.found);
            mismatches++;
          end
          if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            mismatches++;
          end
          if (got.depth !== exp_r.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time, exp_r.depth, got.depth);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        next_wait = rx_burst ? 0 : $urandom_range(0, 16);
      end
      rx_wait = next_wait;
      m_tready <= (next_wait == 0);
    end
  end

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3, 4, 5: return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(input slp_pkg::opcode_t op, input logic [31:0] value,
                         input int unsigned gap, input bit drain);
    stack_req_t q;
    q.op    = op;
    q.value = value;
    q.gap   = gap;
    q.drain = drain;
    pending_reqs.push_back(q);
  endtask

  // random part: fill, drain and mixed stretches so depth sweeps empty to full
  task automatic add_random_reqs();
    int               made;
    int               mode;
    int               len;
    int               pick;
    bit               burst;
    slp_pkg::opcode_t op;
    int unsigned      gap;
    made = 0;
    while (made < RANDOM_REQS) begin
      if (made == 0) begin
        mode = 0;
        len  = 220;
      end else if (made == 220) begin
        mode = 1;
        len  = 260;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(20, 250);
      end
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len && made < RANDOM_REQS; i++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       op = (pick < 75) ? slp_pkg::OP_PUSH : (pick < 82) ? slp_pkg::OP_POP :
                        (pick < 88) ? slp_pkg::OP_PEEK : slp_pkg::OP_SEARCH;
          1:       op = (pick < 10) ? slp_pkg::OP_PUSH : (pick < 75) ? slp_pkg::OP_POP :
                        (pick < 85) ? slp_pkg::OP_PEEK : slp_pkg::OP_SEARCH;
          default: op = (pick < 35) ? slp_pkg::OP_PUSH : (pick < 60) ? slp_pkg::OP_POP :
                        (pick < 75) ? slp_pkg::OP_PEEK : slp_pkg::OP_SEARCH;
        endcase
        gap = burst ? 0 : $urandom_range(0, 16);
        add_req(op, draw_word(), gap, made == 0 || $urandom_range(0, 199) == 0);
        made++;
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    shadow_count = 0;
    // empty-stack corners, then extremes pushed, found and popped back out
    add_req(slp_pkg::OP_POP,    32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_PEEK,   32'hffff_ffff, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'h0000_0000, 1, 1'b0);
    add_req(slp_pkg::OP_PUSH,   32'h7fff_ffff, 0, 1'b0);
    add_req(slp_pkg::OP_PUSH,   32'h8000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_PUSH,   32'hffff_ffff, 3, 1'b0);
    add_req(slp_pkg::OP_PUSH,   32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_PEEK,   32'h1234_5678, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'h7fff_ffff, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'h8000_0000, 2, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'h0000_0001, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'hffff_ffff, 0, 1'b0);
    add_req(slp_pkg::OP_POP,    32'h5555_5555, 0, 1'b0);
    add_req(slp_pkg::OP_POP,    32'haaaa_aaaa, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'hffff_ffff, 0, 1'b0);
    add_req(slp_pkg::OP_POP,    32'h0000_0000, 5, 1'b0);
    add_req(slp_pkg::OP_PEEK,   32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_POP,    32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_POP,    32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_PEEK,   32'h0000_0000, 0, 1'b0);
    add_req(slp_pkg::OP_SEARCH, 32'h7fff_ffff, 0, 1'b0);
    add_random_reqs();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || holding || s_tvalid || expected_resps.size() != 0)
      @(posedge clk);
    // longest search on a full stack is well under this
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("[searchable_lifo_stack] OK");
    end else begin
      $display("[searchable_lifo_stack] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[searchable_lifo_stack] ERROR");
    $finish;
  end

endmodule
